>>> design/display_mode_selector_macros.svh
// assertion macros for the display mode selector
// used by the top level only, no other dependencies
`ifndef DISPLAY_MODE_SELECTOR_MACROS_SVH
`define DISPLAY_MODE_SELECTOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define DMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/dms_pkg.sv
// shared types and constants for the display mode selector
// no dependencies
package dms_pkg;

    localparam int DIM_W     = 16;
    localparam int IDX_W     = 6;
    localparam int AREA_W    = 2 * DIM_W;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_SEL_W = 2;

    localparam logic [REG_SEL_W-1:0] REG_REQ_WIDTH  = 2'd0;
    localparam logic [REG_SEL_W-1:0] REG_REQ_HEIGHT = 2'd1;
    localparam logic [REG_SEL_W-1:0] REG_AXIS_LIMIT = 2'd2;

    localparam int IN_TDATA_W  = 3 * DIM_W;
    localparam int OUT_TDATA_W = 24;

    // one mode after the area and limit stage
    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic [DIM_W-1:0]  refresh;
        logic              exceeds;
        logic              size_match;
        logic              preferred;
        logic              last;
    } mode_info_t;

    // result item, first field in the highest bits
    typedef struct packed {
        logic [IDX_W-1:0] downscale_index;
        logic             downscale_found;
        logic [IDX_W-1:0] preferred_index;
        logic [IDX_W-1:0] match_index;
        logic             match_found;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

>>> design/display_mode_selector.sv
// display mode selector top level: apb registers, mode pipeline, result register
// depends on dms_pkg and display_mode_selector_macros.svh
//
// Takes one display mode per cycle on the s_ stream, lists ending with tlast, and
// gives one result item on the m_ stream per list once its last mode has passed the
// area stage (area multiply and limit compare) and the running-best update. Sustained
// rate is one mode per cycle unless a last mode is held up; the running-best update
// stage (one 32-bit area compare against the stored best) sets that figure. Only a
// result waiting in the output register with m_tready low holds up a last mode, and
// modes behind it wait too. Modes beyond MAX_MODES in a list are ignored.
// Registers: requested width at 0x0, requested height at 0x4, axis limit at 0x8.
module display_mode_selector #(
    parameter int MAX_MODES = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // apb configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dms_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [dms_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [dms_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    // mode stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // mode_width, mode_height, mode_refresh
    input  logic [dms_pkg::IN_TDATA_W-1:0]      s_tdata,
    // mode_preferred
    input  logic                                s_tuser,
    input  logic                                s_tlast,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // match_found, match_index, preferred_index, downscale_found, downscale_index
    output logic [dms_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int CNT_W = $clog2(MAX_MODES + 1);

    // configuration registers
    logic [dms_pkg::DIM_W-1:0] req_width_reg;
    logic [dms_pkg::DIM_W-1:0] req_height_reg;
    logic [dms_pkg::DIM_W-1:0] axis_limit_reg;
    logic [dms_pkg::REG_SEL_W-1:0] reg_sel;
    logic cfg_write;

    // input stage
    logic a_valid_reg;
    logic [dms_pkg::DIM_W-1:0] a_width_reg;
    logic [dms_pkg::DIM_W-1:0] a_height_reg;
    logic [dms_pkg::DIM_W-1:0] a_refresh_reg;
    logic a_pref_reg;
    logic a_last_reg;
    logic a_ready;

    // area stage
    logic b_valid_reg;
    dms_pkg::mode_info_t b_reg;
    dms_pkg::mode_info_t b_next;
    logic b_ready;
    logic b_adv;

    // list state
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W+5:0] cnt_ext;
    logic [dms_pkg::IDX_W-1:0] pos;
    logic in_range;
    logic have_match_reg, have_match_next;
    logic [dms_pkg::IDX_W-1:0] match_pos_reg, match_pos_next;
    logic have_pref_reg, have_pref_next;
    logic [dms_pkg::IDX_W-1:0] pref_pos_reg, pref_pos_next;
    logic pref_big_reg, pref_big_next;
    logic first_big_reg, first_big_next;
    logic have_best_reg, have_best_next;
    logic [dms_pkg::IDX_W-1:0] best_pos_reg, best_pos_next;
    logic [dms_pkg::AREA_W-1:0] best_area_reg, best_area_next;
    logic [dms_pkg::DIM_W-1:0] best_rate_reg, best_rate_next;
    logic too_big;
    logic need;

    // output stage
    logic m_valid_reg;
    dms_pkg::result_t m_data_reg;
    dms_pkg::result_t result;
    logic out_ready;

    // apb
    assign pready    = 1'b1;
    assign reg_sel   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_width_reg  <= '0;
            req_height_reg <= '0;
            axis_limit_reg <= '0;
        end else if (cfg_write) begin
            case (reg_sel)
                dms_pkg::REG_REQ_WIDTH:  req_width_reg  <= pwdata[dms_pkg::DIM_W-1:0];
                dms_pkg::REG_REQ_HEIGHT: req_height_reg <= pwdata[dms_pkg::DIM_W-1:0];
                dms_pkg::REG_AXIS_LIMIT: axis_limit_reg <= pwdata[dms_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            dms_pkg::REG_REQ_WIDTH:  prdata = {16'd0, req_width_reg};
            dms_pkg::REG_REQ_HEIGHT: prdata = {16'd0, req_height_reg};
            dms_pkg::REG_AXIS_LIMIT: prdata = {16'd0, axis_limit_reg};
            default:                 prdata = '0;
        endcase
    end

    // handshake chain
    assign out_ready = !m_valid_reg || m_tready;
    assign b_adv     = b_valid_reg && (!b_reg.last || out_ready);
    assign b_ready   = !b_valid_reg || b_adv;
    assign a_ready   = !a_valid_reg || b_ready;
    assign s_tready  = a_ready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && a_ready) begin
            a_width_reg   <= s_tdata[15:0];
            a_height_reg  <= s_tdata[31:16];
            a_refresh_reg <= s_tdata[47:32];
            a_pref_reg    <= s_tuser;
            a_last_reg    <= s_tlast;
        end
    end

    // area and limit checks
    always_comb begin
        b_next.area       = a_width_reg * a_height_reg;
        b_next.refresh    = a_refresh_reg;
        b_next.exceeds    = (a_width_reg > axis_limit_reg) || (a_height_reg > axis_limit_reg);
        b_next.size_match = (a_width_reg == req_width_reg) && (a_height_reg == req_height_reg);
        b_next.preferred  = a_pref_reg;
        b_next.last       = a_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_valid_reg && b_ready) begin
            b_reg <= b_next;
        end
    end

    // running selection
    assign cnt_ext  = {6'd0, cnt_reg};
    assign pos      = cnt_ext[5:0];
    assign in_range = cnt_reg < CNT_W'(MAX_MODES);

    always_comb begin
        cnt_next        = cnt_reg;
        have_match_next = have_match_reg;
        match_pos_next  = match_pos_reg;
        have_pref_next  = have_pref_reg;
        pref_pos_next   = pref_pos_reg;
        pref_big_next   = pref_big_reg;
        first_big_next  = first_big_reg;
        have_best_next  = have_best_reg;
        best_pos_next   = best_pos_reg;
        best_area_next  = best_area_reg;
        best_rate_next  = best_rate_reg;
        if (in_range) begin
            if (!have_match_reg && b_reg.size_match) begin
                have_match_next = 1'b1;
                match_pos_next  = pos;
            end
            if (!have_pref_reg && b_reg.preferred) begin
                have_pref_next = 1'b1;
                pref_pos_next  = pos;
                pref_big_next  = b_reg.exceeds;
            end
            if (cnt_reg == '0) begin
                first_big_next = b_reg.exceeds;
            end
            if (!b_reg.exceeds && ((b_reg.area > best_area_reg) ||
                                   (b_reg.area == best_area_reg &&
                                    b_reg.refresh > best_rate_reg))) begin
                have_best_next = 1'b1;
                best_pos_next  = pos;
                best_area_next = b_reg.area;
                best_rate_next = b_reg.refresh;
            end
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_comb begin
        too_big                = have_pref_next ? pref_big_next : first_big_next;
        need                   = too_big && have_best_next;
        result.match_found     = have_match_next;
        result.match_index     = have_match_next ? match_pos_next : '0;
        result.preferred_index = have_pref_next ? pref_pos_next : '0;
        result.downscale_found = need;
        result.downscale_index = need ? best_pos_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (b_adv && b_reg.last)) begin
            cnt_reg        <= '0;
            have_match_reg <= 1'b0;
            match_pos_reg  <= '0;
            have_pref_reg  <= 1'b0;
            pref_pos_reg   <= '0;
            pref_big_reg   <= 1'b0;
            first_big_reg  <= 1'b0;
            have_best_reg  <= 1'b0;
            best_pos_reg   <= '0;
            best_area_reg  <= '0;
            best_rate_reg  <= '0;
        end else if (b_adv) begin
            cnt_reg        <= cnt_next;
            have_match_reg <= have_match_next;
            match_pos_reg  <= match_pos_next;
            have_pref_reg  <= have_pref_next;
            pref_pos_reg   <= pref_pos_next;
            pref_big_reg   <= pref_big_next;
            first_big_reg  <= first_big_next;
            have_best_reg  <= have_best_next;
            best_pos_reg   <= best_pos_next;
            best_area_reg  <= best_area_next;
            best_rate_reg  <= best_rate_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_adv && b_reg.last) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_adv && b_reg.last) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(dms_pkg::OUT_TDATA_W - dms_pkg::RESULT_W)'(0), m_data_reg};

`include "display_mode_selector_macros.svh"

    `DMS_ASSERT_IMPLY(a_match_idx_zero, aclk, aresetn, m_valid_reg && !m_data_reg.match_found, m_data_reg.match_index == '0, "match index set without a match")
    `DMS_ASSERT_IMPLY(a_down_idx_zero, aclk, aresetn, m_valid_reg && !m_data_reg.downscale_found, m_data_reg.downscale_index == '0, "downscale index set without a choice")
    `DMS_ASSERT_IMPLY(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(MAX_MODES), "mode count past limit")
    `DMS_ASSERT_NEXT(a_clear_after_last, aclk, aresetn, b_adv && b_reg.last, cnt_reg == '0 && !have_best_reg && m_valid_reg, "list state not cleared after last item")

endmodule
